>>> rtl/psbl_pkg.sv
// ----------------------------------------------------------------------------
// psbl_pkg
// shared types and constants for the prefix sum bucket locator
// ----------------------------------------------------------------------------
package psbl_pkg;

  localparam int VAL_W   = 48;   // bucket size, position and running total width
  localparam int IDX_W   = 11;   // width of the reported bucket index
  localparam int Q_DEPTH = 2;    // entries in the front to back queue
  localparam int Q_PW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } psbl_op_t;

  typedef struct packed {
    psbl_op_t           op;
    logic [VAL_W-1:0]   value;
  } psbl_entry_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_ADDR,
    B_CMP,
    B_DONE
  } psbl_bstate_t;

endpackage

>>> rtl/prefix_sum_bucket_locate.sv
// ----------------------------------------------------------------------------
// prefix_sum_bucket_locate
// running total table of bucket sizes with lower bound position lookup
// ----------------------------------------------------------------------------
//
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  input    | in_valid, in_ready, in_func, in_value         | in
//  result   | out_valid, out_ready, out_bucket_index,       | out
//           | out_offset, out_past_end                      |
//
//  an append gives no result word
//  a query runs a binary search over the loaded buckets in the back end:
//  each search step is one read of the totals ram, whose registered read
//  port sets the step time
//  a two word queue sits between the input side and the search engine, and
//  a result register sits on the output, so input keeps flowing while one
//  finished result waits; a second finished result holds the back end and
//  the input stalls once the queue is full
//  reset (rst_n low, synchronous) empties the queue and sets the bucket count
//  to zero; the totals ram is not cleared, only written entries are read
//
module prefix_sum_bucket_locate
  import psbl_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [VAL_W-1:0]  in_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_bucket_index,
  output logic [VAL_W-1:0]  out_offset,
  output logic              out_past_end
);

  // queue between front and back
  logic         q_valid;
  logic         q_ready;
  psbl_entry_t  q_entry;

  // front: accept the word, decode append or query, queue it
  psbl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_func  (in_func),
    .in_value (in_value),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_entry  (q_entry)
  );

  // back: appends write the next running total unless the table is full,
  // queries binary search the totals for the first one at least the position
  psbl_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_ready          (q_ready),
    .q_entry          (q_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bucket_index (out_bucket_index),
    .out_offset       (out_offset),
    .out_past_end     (out_past_end)
  );

endmodule

>>> rtl/psbl_ram.sv
// ----------------------------------------------------------------------------
// psbl_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module psbl_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

>>> rtl/psbl_front.sv
// ----------------------------------------------------------------------------
// psbl_front
// accepts input words, decodes the operation and queues them for the back end
// ----------------------------------------------------------------------------
module psbl_front
  import psbl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_func,
  input  logic [VAL_W-1:0]  in_value,
  output logic              q_valid,
  input  logic              q_ready,
  output psbl_entry_t       q_entry
);

  psbl_entry_t       slot_r [Q_DEPTH];
  logic [Q_PW-1:0]   wr_ptr_r;
  logic [Q_PW-1:0]   rd_ptr_r;
  logic [Q_CW-1:0]   cnt_r;
  logic              push;
  logic              pop;
  psbl_entry_t       new_entry;

  assign in_ready = (cnt_r != Q_CW'(Q_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_entry  = slot_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // classify the word
  always_comb begin
    new_entry.op    = in_func ? OP_QUERY : OP_APPEND;
    new_entry.value = in_value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

endmodule

>>> rtl/psbl_back.sv
// ----------------------------------------------------------------------------
// psbl_back
// executes appends and runs the lower bound search over the running totals
// ----------------------------------------------------------------------------
module psbl_back
  import psbl_pkg::*;
#(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  psbl_entry_t       q_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_bucket_index,
  output logic [VAL_W-1:0]  out_offset,
  output logic              out_past_end
);

  localparam int CW = $clog2(MAX_ENTRIES + 2);
  localparam int AW = $clog2(MAX_ENTRIES);

  psbl_bstate_t      state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [VAL_W-1:0]  grand_r, grand_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [VAL_W-1:0]  prev_r, prev_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;

  logic              take;
  logic              out_load;
  logic              ram_wr_en;
  logic              ram_rd_en;
  logic [AW-1:0]     ram_rd_addr;
  logic [VAL_W-1:0]  ram_rd_data;
  logic [VAL_W:0]    add_sum;
  logic [VAL_W-1:0]  sat_total;
  logic              full;
  logic [CW-1:0]     mid_calc;
  logic [CW-1:0]     mid_less1;
  logic              out_free;

  assign full      = (count_r == CW'(MAX_ENTRIES));
  assign add_sum   = {1'b0, grand_r} + {1'b0, q_entry.value};
  assign sat_total = add_sum[VAL_W] ? {VAL_W{1'b1}} : add_sum[VAL_W-1:0];
  assign mid_calc  = lo_r + ((hi_r - lo_r) >> 1);
  assign mid_less1 = mid_calc - CW'(1);
  assign ram_rd_addr = mid_less1[AW-1:0];
  assign out_free  = !out_valid || out_ready;

  psbl_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_ENTRIES)
  ) u_totals (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (sat_total),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (q_valid && q_entry.op == OP_QUERY) begin
          state_nxt = B_ADDR;
        end
      end
      B_ADDR: begin
        state_nxt = (lo_r < hi_r) ? B_CMP : B_DONE;
      end
      B_CMP: begin
        state_nxt = B_ADDR;
      end
      B_DONE: begin
        if (out_free) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // control outputs
  always_comb begin
    take      = 1'b0;
    ram_wr_en = 1'b0;
    ram_rd_en = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      B_IDLE: begin
        take      = q_valid;
        ram_wr_en = q_valid && q_entry.op == OP_APPEND && !full;
      end
      B_ADDR: begin
        ram_rd_en = (lo_r < hi_r);
      end
      B_CMP: begin
      end
      B_DONE: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  assign q_ready = take;

  // search datapath
  always_comb begin
    count_nxt = count_r;
    grand_nxt = grand_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    prev_nxt  = prev_r;
    val_nxt   = val_r;
    if (ram_wr_en) begin
      count_nxt = count_r + CW'(1);
      grand_nxt = sat_total;
    end
    if (take && q_entry.op == OP_QUERY) begin
      val_nxt  = q_entry.value;
      lo_nxt   = CW'(1);
      hi_nxt   = count_r + CW'(1);
      prev_nxt = '0;
    end
    if (ram_rd_en) begin
      mid_nxt = mid_calc;
    end
    if (state_r == B_CMP) begin
      if (ram_rd_data >= val_r) begin
        hi_nxt = mid_r;
      end else begin
        lo_nxt   = mid_r + CW'(1);
        prev_nxt = ram_rd_data;   // total of buckets 1..lo-1
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      count_r <= '0;
      grand_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      grand_r <= grand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    prev_r <= prev_nxt;
    val_r  <= val_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bucket_index <= IDX_W'(lo_r);
      out_offset       <= val_r - prev_r;
      out_past_end     <= (lo_r > count_r);
    end
  end

endmodule

>>> rtl/psbl_checker.sv
// ----------------------------------------------------------------------------
// psbl_checker
// port level checks on the prefix sum bucket locator
// ----------------------------------------------------------------------------
module psbl_checker
  import psbl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              in_func,
  input  logic [VAL_W-1:0]  in_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [IDX_W-1:0]  out_bucket_index,
  input  logic [VAL_W-1:0]  out_offset,
  input  logic              out_past_end
);

  logic [3:0] pending_r;
  logic       seen_append_r;
  logic       q_acc;
  logic       a_acc;
  logic       o_acc;

  assign q_acc = in_valid && in_ready && in_func;
  assign a_acc = in_valid && in_ready && !in_func;
  assign o_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r     <= '0;
      seen_append_r <= 1'b0;
    end else begin
      if (q_acc && !o_acc) begin
        pending_r <= pending_r + 4'd1;
      end else if (o_acc && !q_acc && pending_r != '0) begin
        pending_r <= pending_r - 4'd1;
      end
      if (a_acc) begin
        seen_append_r <= 1'b1;
      end
    end
  end

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_func) && $stable(in_value))
    else $error("input word changed while stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bucket_index)
      && $stable(out_offset) && $stable(out_past_end))
    else $error("result changed while stalled");

  // no result word is shown right after reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // every delivered result belongs to an earlier query
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    o_acc |-> pending_r != '0)
    else $error("result without a pending query");

  // with an empty table a query lands past the end in bucket one
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !seen_append_r |-> out_past_end && out_bucket_index == IDX_W'(1))
    else $error("wrong answer on empty table");

endmodule

bind prefix_sum_bucket_locate psbl_checker u_psbl_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_func          (in_func),
  .in_value         (in_value),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_bucket_index (out_bucket_index),
  .out_offset       (out_offset),
  .out_past_end     (out_past_end)
);
